@@ rtl/b64e_pkg.sv @@
// Shared constants, types and the alphabet lookup for the Base64 encoder.
package b64e_pkg;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROTATION = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PAD      = 1'd1;

    // Reset values of the configuration registers.
    localparam logic [5:0] ROTATION_RST = 6'd24;
    localparam logic [7:0] PAD_RST      = 8'd61;

    // Group phase codes: bytes already taken in the current 3-byte group.
    localparam logic [1:0] PH_FIRST  = 2'd0;
    localparam logic [1:0] PH_SECOND = 2'd1;
    localparam logic [1:0] PH_THIRD  = 2'd2;
    localparam logic [1:0] PH_UNUSED = 2'd3;

    // Most characters one byte can cause.
    localparam int MAX_CHARS = 4;
    localparam int CNT_W     = 3;

    // Scrambled alphabet, first character in the top byte.
    localparam logic [8*64-1:0] ALPHABET =
        "GLp/+Wn7uqX8FQ2JDR1c0M6U53sjBwyxglmrCVdSThAfEOvPHaYZNzo4ktK9iebI";

    // Characters and next state produced for one byte.
    typedef struct packed {
        logic [MAX_CHARS-1:0][7:0] chars;
        logic [CNT_W-1:0]          count;
        logic [1:0]                phase;
        logic [3:0]                leftover;
    } t_grp_res;

    // Rotate a six-bit value modulo 64 and look it up in the alphabet.
    function automatic logic [7:0] map6(input logic [5:0] v, input logic [5:0] rot);
        logic [5:0] idx;
        logic [5:0] pos;
        idx = v + rot;
        pos = 6'd63 - idx;
        return ALPHABET[{pos, 3'b000} +: 8];
    endfunction

endpackage

@@ rtl/b64e_group.sv @@
// Combinational encoding of one byte into up to four characters.
module b64e_group (
    input  logic [7:0]          i_byte,
    input  logic                i_fin,
    input  logic [1:0]          i_phase,
    input  logic [3:0]          i_leftover,
    input  logic [5:0]          i_rotation,
    input  logic [7:0]          i_pad,
    output b64e_pkg::t_grp_res  o_res
);
    import b64e_pkg::*;

    logic [1:0] ph;

    // The unused phase code behaves as the start of a group.
    assign ph = (i_phase == PH_UNUSED) ? PH_FIRST : i_phase;

    always_comb begin
        o_res.chars    = '0;
        o_res.count    = CNT_W'(1);
        o_res.phase    = PH_FIRST;
        o_res.leftover = 4'd0;
        case (ph)
            PH_SECOND: begin
                o_res.chars[0] = map6({i_leftover[1:0], i_byte[7:4]}, i_rotation);
                if (i_fin) begin
                    o_res.chars[1] = map6({i_byte[3:0], 2'b00}, i_rotation);
                    o_res.chars[2] = i_pad;
                    o_res.count    = CNT_W'(3);
                end else begin
                    o_res.phase    = PH_THIRD;
                    o_res.leftover = i_byte[3:0];
                end
            end
            PH_THIRD: begin
                o_res.chars[0] = map6({i_leftover, i_byte[7:6]}, i_rotation);
                o_res.chars[1] = map6(i_byte[5:0], i_rotation);
                o_res.count    = CNT_W'(2);
            end
            default: begin
                o_res.chars[0] = map6(i_byte[7:2], i_rotation);
                if (i_fin) begin
                    o_res.chars[1] = map6({i_byte[1:0], 4'b0000}, i_rotation);
                    o_res.chars[2] = i_pad;
                    o_res.chars[3] = i_pad;
                    o_res.count    = CNT_W'(4);
                end else begin
                    o_res.phase    = PH_SECOND;
                    o_res.leftover = {2'b00, i_byte[1:0]};
                end
            end
        endcase
    end

endmodule

@@ rtl/base64_custom_alphabet_encoder.sv @@
// Streaming Base64 encoder with a rotated, scrambled alphabet.
//
//  Channel  | Handshake                   | Payload
//  ---------+-----------------------------+-------------------------------------
//  input    | i_in_valid / o_in_ready     | i_data_byte, i_final_byte
//  output   | o_out_valid / i_out_ready   | o_out_char, o_end_of_run,
//           |                             | o_end_of_message
//  config   | i_cfg_valid / o_cfg_ready   | i_cfg_index, i_cfg_data
//
// A byte is taken into an input register, encoded combinationally into a
// character buffer, and its characters leave one per cycle from that buffer
// while the receiver is ready. A byte therefore gives one, two, three or four
// characters (its character count), all through the single character port.
// The input register takes the next byte while the last character still waits.
// Synchronous reset empties the buffers, clears group state and presets config.
// Output stalls back up into the input register and then into o_in_ready.
module base64_custom_alphabet_encoder (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [7:0]                      i_data_byte,
    input  logic                            i_final_byte,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [7:0]                      o_out_char,
    output logic                            o_end_of_run,
    output logic                            o_end_of_message,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [b64e_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [7:0]                      i_cfg_data
);
    import b64e_pkg::*;

    logic [5:0]                r_rotation;
    logic [7:0]                r_pad;
    logic                      r_in_vld;
    logic [7:0]                r_in_byte;
    logic                      r_in_fin;
    logic [1:0]                r_phase;
    logic [3:0]                r_leftover;
    logic [MAX_CHARS-1:0][7:0] r_chars;
    logic [CNT_W-1:0]          r_cnt;
    logic                      r_fin;

    logic [MAX_CHARS-1:0][7:0] n_chars;
    logic [CNT_W-1:0]          n_cnt;
    logic                      w_out_beat;
    logic                      w_load;
    t_grp_res                  w_res;

    // Configuration writes are always taken.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rotation <= ROTATION_RST;
            r_pad      <= PAD_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_ROTATION: r_rotation <= i_cfg_data[5:0];
                CFG_PAD:      r_pad      <= i_cfg_data;
                default:      r_pad      <= r_pad;
            endcase
        end
    end

    // The buffer takes a new byte when empty or when its last character leaves.
    assign w_out_beat = o_out_valid && i_out_ready;
    assign w_load     = r_in_vld &&
                        ((r_cnt == '0) || ((r_cnt == CNT_W'(1)) && i_out_ready));
    assign o_in_ready = !r_in_vld || w_load;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_in_ready) begin
            r_in_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_byte <= i_data_byte;
            r_in_fin  <= i_final_byte;
        end
    end

    // Encode the registered byte against the group state.
    b64e_group u_group (
        .i_byte     (r_in_byte),
        .i_fin      (r_in_fin),
        .i_phase    (r_phase),
        .i_leftover (r_leftover),
        .i_rotation (r_rotation),
        .i_pad      (r_pad),
        .o_res      (w_res)
    );

    // Group state advances when a byte enters the buffer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_FIRST;
            r_leftover <= 4'd0;
        end else if (w_load) begin
            r_phase    <= w_res.phase;
            r_leftover <= w_res.leftover;
        end
    end

    // Character buffer: load on a new byte, shift down on each output beat.
    always_comb begin
        n_chars = r_chars;
        n_cnt   = r_cnt;
        if (w_load) begin
            n_chars = w_res.chars;
            n_cnt   = w_res.count;
        end else if (w_out_beat) begin
            n_chars = {8'h00, r_chars[MAX_CHARS-1:1]};
            n_cnt   = r_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_chars <= n_chars;
        if (w_load) begin
            r_fin <= r_in_fin;
        end
    end

    // Output port.
    assign o_out_valid      = (r_cnt != '0);
    assign o_out_char       = r_chars[0];
    assign o_end_of_run     = (r_cnt == CNT_W'(1));
    assign o_end_of_message = (r_cnt == CNT_W'(1)) && r_fin;

    // The buffer never holds more than one byte's characters.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(MAX_CHARS))
        else $error("character count above four");

    // The unused phase code is never reached.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase != PH_UNUSED)
        else $error("group phase took the unused code");

    // After the first byte of a group only two leftover bits are kept.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_SECOND) |-> (r_leftover[3:2] == 2'b00))
        else $error("leftover bits too wide for the second phase");

    // The last character leaving with nothing to load empties the buffer.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_beat && o_end_of_run && !w_load) |=> !o_out_valid)
        else $error("buffer not empty after the last character");

    // A loaded byte shows its first character in the next cycle.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |=> o_out_valid)
        else $error("loaded byte produced no character");

endmodule

@@ verif/base64_custom_alphabet_encoder_checker.sv @@
// Checker for the Base64 encoder: predicts every character and compares it at the output.
module base64_custom_alphabet_encoder_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    input  logic                           i_in_ready,
    input  logic [7:0]                     i_data_byte,
    input  logic                           i_final_byte,
    input  logic                           i_out_valid,
    input  logic                           i_out_ready,
    input  logic [7:0]                     i_out_char,
    input  logic                           i_end_of_run,
    input  logic                           i_end_of_message,
    input  logic                           i_cfg_valid,
    input  logic                           i_cfg_ready,
    input  logic [b64e_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [7:0]                     i_cfg_data,
    output int                             o_fail_count,
    output int                             o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import b64e_pkg::*;

    // Scrambled alphabet; the character for index 0 sits in the top byte.
    localparam logic [8*64-1:0] SCRAMBLED =
        "GLp/+Wn7uqX8FQ2JDR1c0M6U53sjBwyxglmrCVdSThAfEOvPHaYZNzo4ktK9iebI";

    // One predicted output beat.
    typedef struct packed {
        logic [7:0] ch;
        logic       run_end;
        logic       msg_end;
    } t_enc_char;

    t_enc_char  expected_chars [$];
    logic [5:0] rotation;
    logic [7:0] pad;
    logic [1:0] phase;
    logic [3:0] carry;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    // Rotate a six-bit value modulo 64 and look it up.
    function automatic logic [7:0] lookup(input logic [5:0] v);
        logic [5:0] idx;
        idx = v + rotation;
        return SCRAMBLED[(63 - idx) * 8 +: 8];
    endfunction

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        $display("%0t ns: mismatch on %s: got %02h, expected %02h", $time, what, got, want);
        o_fail_count++;
    endtask

    // Work out the characters one accepted byte causes and queue them.
    task automatic encode_byte(input logic [7:0] b, input logic fin);
        logic [7:0] chars [$];
        case (phase)
            PH_SECOND: begin
                chars.push_back(lookup({carry[1:0], b[7:4]}));
                if (fin) begin
                    chars.push_back(lookup({b[3:0], 2'b00}));
                    chars.push_back(pad);
                end else begin
                    phase = PH_THIRD;
                    carry = b[3:0];
                end
            end
            PH_THIRD: begin
                chars.push_back(lookup({carry, b[7:6]}));
                chars.push_back(lookup(b[5:0]));
                phase = PH_FIRST;
                carry = '0;
            end
            default: begin
                // First byte of a group; the unused fourth phase code acts the same.
                chars.push_back(lookup(b[7:2]));
                if (fin) begin
                    chars.push_back(lookup({b[1:0], 4'b0000}));
                    chars.push_back(pad);
                    chars.push_back(pad);
                end else begin
                    phase = PH_SECOND;
                    carry = {2'b00, b[1:0]};
                end
            end
        endcase
        if (fin) begin
            phase = PH_FIRST;
            carry = '0;
        end
        foreach (chars[k]) begin
            expected_chars.push_back('{ch: chars[k],
                                       run_end: (k == chars.size() - 1),
                                       msg_end: (fin && k == chars.size() - 1)});
        end
    endtask

    // Watch all three channels; outputs are checked before the byte of the same edge.
    always @(posedge i_clk) begin
        t_enc_char due;
        if (!i_rst_n) begin
            expected_chars.delete();
            rotation = ROTATION_RST;
            pad      = PAD_RST;
            phase    = PH_FIRST;
            carry    = '0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (expected_chars.size() == 0) begin
                    report_mismatch("unexpected character", i_out_char, 8'h00);
                end else begin
                    due = expected_chars.pop_front();
                    if (i_out_char !== due.ch)
                        report_mismatch("out_char", i_out_char, due.ch);
                    if (i_end_of_run !== due.run_end)
                        report_mismatch("end_of_run", {7'd0, i_end_of_run},
                                        {7'd0, due.run_end});
                    if (i_end_of_message !== due.msg_end)
                        report_mismatch("end_of_message", {7'd0, i_end_of_message},
                                        {7'd0, due.msg_end});
                end
            end
            if (i_in_valid && i_in_ready)
                encode_byte(i_data_byte, i_final_byte);
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == CFG_ROTATION)
                    rotation = i_cfg_data[5:0];
                else if (i_cfg_index == CFG_PAD)
                    pad = i_cfg_data;
            end
        end
        o_pending <= expected_chars.size();
    end

endmodule

@@ verif/base64_custom_alphabet_encoder_test.sv @@
// Testbench top for the Base64 encoder: clock, reset, stimulus, output stalls and verdict.
module base64_custom_alphabet_encoder_test;
    timeunit 1ns;
    timeprecision 1ps;

    import b64e_pkg::*;

    logic                 clk        = 1'b0;
    logic                 rst_n      = 1'b0;
    logic                 in_valid   = 1'b0;
    logic [7:0]           data_byte  = 8'h00;
    logic                 final_byte = 1'b0;
    logic                 out_ready  = 1'b0;
    logic                 cfg_valid  = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index  = CFG_ROTATION;
    logic [7:0]           cfg_data   = 8'h00;

    logic       in_ready;
    logic       out_valid;
    logic [7:0] out_char;
    logic       end_of_run;
    logic       end_of_message;
    logic       cfg_ready;
    int         fail_count;
    int         pending;

    // Set by the stimulus, cleared by the receiver when its long hold-off starts.
    bit long_hold_req = 1'b0;

    base64_custom_alphabet_encoder DUT (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .o_in_ready       (in_ready),
        .i_data_byte      (data_byte),
        .i_final_byte     (final_byte),
        .o_out_valid      (out_valid),
        .i_out_ready      (out_ready),
        .o_out_char       (out_char),
        .o_end_of_run     (end_of_run),
        .o_end_of_message (end_of_message),
        .i_cfg_valid      (cfg_valid),
        .o_cfg_ready      (cfg_ready),
        .i_cfg_index      (cfg_index),
        .i_cfg_data       (cfg_data)
    );

    base64_custom_alphabet_encoder_checker checker_inst (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .i_in_ready       (in_ready),
        .i_data_byte      (data_byte),
        .i_final_byte     (final_byte),
        .i_out_valid      (out_valid),
        .i_out_ready      (out_ready),
        .i_out_char       (out_char),
        .i_end_of_run     (end_of_run),
        .i_end_of_message (end_of_message),
        .i_cfg_valid      (cfg_valid),
        .i_cfg_ready      (cfg_ready),
        .i_cfg_index      (cfg_index),
        .i_cfg_data       (cfg_data),
        .o_fail_count     (fail_count),
        .o_pending        (pending)
    );

    // 12 ns clock.
    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Receiver: mostly ready, short and long stalls, calm stretches, one long hold-off.
    int stall_left = 0;
    int calm_left  = 0;
    always @(posedge clk) begin
        int roll;
        roll = $urandom_range(0, 99);
        if (stall_left != 0) begin
            stall_left--;
            out_ready <= 1'b0;
        end else if (long_hold_req) begin
            long_hold_req = 1'b0;
            stall_left    = 150;
            out_ready <= 1'b0;
        end else if (calm_left != 0) begin
            calm_left--;
            out_ready <= 1'b1;
        end else if (roll < 60) begin
            out_ready <= 1'b1;
        end else if (roll < 88) begin
            out_ready <= 1'b0;
            stall_left = $urandom_range(0, 3);
        end else if (roll < 96) begin
            out_ready <= 1'b1;
            calm_left = $urandom_range(10, 40);
        end else begin
            out_ready <= 1'b0;
            stall_left = $urandom_range(10, 40);
        end
    end

    // Idle cycles after a byte: mostly none, some short, a few long.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 65)
            return 0;
        else if (roll < 93)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 25);
    endfunction

    // Offer one byte, hold it until the beat is taken, then idle for the given gap.
    task automatic send_byte(input logic [7:0] b, input logic fin, input int gap);
        data_byte  <= b;
        final_byte <= fin;
        in_valid   <= 1'b1;
        do @(posedge clk); while (!in_ready);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Register write; valid stays high so back-to-back writes need no lowering.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] value);
        cfg_index <= idx;
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
    endtask

    // Stop sending and wait until every predicted character has come out.
    task automatic wait_drained();
        in_valid <= 1'b0;
        repeat (2) @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Directed messages: one to six bytes, ending at every group phase, extreme bytes.
    byte unsigned dir_bytes [24] = '{8'h00, 8'hff, 8'h00, 8'hff, 8'hff, 8'h00,
                                     8'h12, 8'h34, 8'h56, 8'hff, 8'hff, 8'hff, 8'hff,
                                     8'ha5, 8'h5a, 8'hc3, 8'h3c, 8'h0f,
                                     8'h01, 8'h80, 8'h7e, 8'he7, 8'h24, 8'h42};
    bit dir_last [24] = '{1, 1, 0, 1, 0, 1, 0, 0, 1, 0, 0, 0, 1,
                          0, 0, 0, 0, 1, 0, 0, 0, 0, 0, 1};

    // Main stimulus.
    initial begin
        int         sent;
        int         len;
        int         roll;
        bit         burst;
        bit         paused;
        logic [7:0] rot_value;
        logic [7:0] pad_value;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part under the reset configuration.
        foreach (dir_bytes[i])
            send_byte(dir_bytes[i], dir_last[i], (i % 3 == 2) ? $urandom_range(1, 4) : 0);

        // Random messages under several register settings, extremes first.
        for (int setting = 0; setting < 6; setting++) begin
            wait_drained();
            case (setting)
                0: begin
                    rot_value = {2'($urandom_range(0, 3)), 6'd0};
                    pad_value = 8'h00;
                end
                1: begin
                    rot_value = {2'($urandom_range(0, 3)), 6'd63};
                    pad_value = 8'hff;
                end
                default: begin
                    rot_value = 8'($urandom_range(0, 255));
                    pad_value = 8'($urandom_range(0, 255));
                end
            endcase
            write_reg(CFG_ROTATION, rot_value);
            write_reg(CFG_PAD, pad_value);
            cfg_valid <= 1'b0;
            @(posedge clk);

            // The receiver holds off while bytes keep coming, so the block backs up.
            if (setting == 1)
                long_hold_req = 1'b1;

            sent   = 0;
            paused = 1'b0;
            while (sent < 53) begin
                roll = $urandom_range(0, 99);
                if (roll < 70)
                    len = $urandom_range(1, 6);
                else if (roll < 95)
                    len = $urandom_range(7, 15);
                else
                    len = $urandom_range(16, 30);
                burst = (setting == 1 && sent < 40) || ($urandom_range(0, 3) == 0);
                for (int j = 0; j < len; j++) begin
                    send_byte(8'($urandom_range(0, 255)), j == len - 1,
                              burst ? 0 : pick_gap());
                    sent++;
                end
                // Sender pauses mid-setting until all characters have come out.
                if (setting == 2 && !paused && sent >= 29) begin
                    paused = 1'b1;
                    wait_drained();
                end
            end
        end

        wait_drained();
        repeat (20) @(posedge clk);
        if (fail_count == 0)
            $display("base64_custom_alphabet_encoder_test: done, clean");
        else
            $display("base64_custom_alphabet_encoder_test: done, errors");
        $finish;
    end

    // Run limit: about 370 bytes of up to four characters, each waiting out the longest
    // random stall, plus sender gaps, stays far below this timeout.
    initial begin
        #8_000_000;
        $display("base64_custom_alphabet_encoder_test: done, errors");
        $finish;
    end

endmodule

@@ files.f @@
rtl/b64e_pkg.sv
rtl/b64e_group.sv
rtl/base64_custom_alphabet_encoder.sv
verif/base64_custom_alphabet_encoder_checker.sv
verif/base64_custom_alphabet_encoder_test.sv
